// ===== rtl/msp_pkg.sv =====
// Shared constants for the matrix saddle point detector.
// Defines field widths, register layout and defaults; no dependencies.
package msp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAX_DIM    = 16;

  // Count registers: 5 bits, reset to a 3x3 matrix.
  localparam int            CNT_W     = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd3;

  // APB register file: 32-bit data, registers at byte offsets 0 and 4.
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register index, taken from paddr above the byte offset.
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

endpackage

// ===== rtl/msp_elem_if.sv =====
// Input channel: one matrix element word per handshake.
// Depends on msp_pkg for the default data width.
interface msp_elem_if #(
  parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// ===== rtl/msp_result_if.sv =====
// Output channel: one saddle point result word per matrix.
// Depends on msp_pkg for the default data width.
interface msp_result_if #(
  parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic                         saddle_exists;
  logic signed [DATA_WIDTH-1:0] saddle_value;

  modport source (output valid, output saddle_exists, output saddle_value, input ready);
  modport sink   (input valid, input saddle_exists, input saddle_value, output ready);
endinterface

// ===== rtl/matrix_saddle_point_detector_top.sv =====
// Matrix saddle point detector: a matrix's last element word passes from the accept cycle
// (stage A) through stage B into the result register, which then drives the result word;
// throughput is one element word per cycle while the input is not stalled.
// Input stalls only while a result is held unread and the next result is ready to leave.
// Reset (rst_ni low, asynchronous) clears counters, running extrema and pipeline valids,
// and loads both count registers with 3; the column maximum memory needs no clearing pass.
// Depends on msp_pkg, msp_elem_if, msp_result_if and msp_ram.
module matrix_saddle_point_detector_top #(
  parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH,
  parameter int MAX_DIM    = msp_pkg::MAX_DIM
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  msp_elem_if.sink                    elem_i,
  msp_result_if.source                result_o,
  // APB register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [msp_pkg::APB_AW-1:0]  paddr,
  input  logic [msp_pkg::APB_DW-1:0]  pwdata,
  output logic [msp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int PosW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CntW = $clog2(MAX_DIM + 1);

  // ---------------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------------
  logic [msp_pkg::CNT_W-1:0]     row_count_q, col_count_q;
  logic [msp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[msp_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= msp_pkg::CNT_RESET;
      col_count_q <= msp_pkg::CNT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        msp_pkg::REG_ROW_COUNT: row_count_q <= pwdata[msp_pkg::CNT_W-1:0];
        msp_pkg::REG_COL_COUNT: col_count_q <= pwdata[msp_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      msp_pkg::REG_ROW_COUNT: prdata = msp_pkg::APB_DW'(row_count_q);
      msp_pkg::REG_COL_COUNT: prdata = msp_pkg::APB_DW'(col_count_q);
      default:                prdata = '0;
    endcase
  end

  // Clamp counts: zero acts as one, anything above MAX_DIM acts as MAX_DIM.
  logic [CntW-1:0] rows_eff, cols_eff;

  always_comb begin
    if (row_count_q == '0) begin
      rows_eff = CntW'(1);
    end else if (32'(row_count_q) > 32'(MAX_DIM)) begin
      rows_eff = CntW'(MAX_DIM);
    end else begin
      rows_eff = CntW'(row_count_q);
    end
    if (col_count_q == '0) begin
      cols_eff = CntW'(1);
    end else if (32'(col_count_q) > 32'(MAX_DIM)) begin
      cols_eff = CntW'(MAX_DIM);
    end else begin
      cols_eff = CntW'(col_count_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control
  // ---------------------------------------------------------------------------
  // Stage A is the accept cycle: it issues the column memory read and updates
  // the row running minimum and the maximin. Stage B gets the read data,
  // writes the column maximum back, updates the minimax and fills the result
  // register. Only a result waiting on a full output register stalls stage B.
  logic accept, stall, b_fire;
  logic b_valid_q;
  logic b_emit_q;
  logic res_valid_q;

  assign stall        = b_valid_q && b_emit_q && res_valid_q && !result_o.ready;
  assign elem_i.ready = !stall;
  assign accept       = elem_i.valid && !stall;
  assign b_fire       = b_valid_q && !stall;

  // ---------------------------------------------------------------------------
  // Stage A: positions, row minimum, maximin
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]              row_pos_q, row_pos_d;
  logic [PosW-1:0]              col_pos_q, col_pos_d;
  logic signed [DATA_WIDTH-1:0] cur_min_q, cur_min_d;
  logic signed [DATA_WIDTH-1:0] best_q, best_d;
  logic signed [DATA_WIDTH-1:0] elem_v;
  logic                         is_last_col, is_last_row, is_r0, is_c0;

  assign elem_v      = elem_i.element;
  assign is_r0       = (row_pos_q == '0);
  assign is_c0       = (col_pos_q == '0);
  assign is_last_col = (32'(col_pos_q) + 32'd1) >= 32'(cols_eff);
  assign is_last_row = (32'(row_pos_q) + 32'd1) >= 32'(rows_eff);

  always_comb begin
    cur_min_d = cur_min_q;
    best_d    = best_q;
    row_pos_d = row_pos_q;
    col_pos_d = col_pos_q;
    if (accept) begin
      if (is_c0 || elem_v < cur_min_q) begin
        cur_min_d = elem_v;
      end
      // Close the row: fold its minimum into the maximin.
      if (is_last_col && (is_r0 || cur_min_d > best_q)) begin
        best_d = cur_min_d;
      end
      // Advance the raster position, wrap at the end of the matrix.
      if (is_last_col) begin
        col_pos_d = '0;
        row_pos_d = is_last_row ? '0 : row_pos_q + PosW'(1);
      end else begin
        col_pos_d = col_pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      col_pos_q <= '0;
      cur_min_q <= '0;
      best_q    <= '0;
    end else begin
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
      cur_min_q <= cur_min_d;
      best_q    <= best_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Column maximum memory and stage B
  // ---------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0]        ram_rdata;
  logic signed [DATA_WIDTH-1:0] col_old, col_new;
  logic signed [DATA_WIDTH-1:0] least_q, least_d;

  // Stage B word: element, column address and position flags, plus the
  // maximin as it stood after this element (a one-column matrix overwrites
  // it on the very next accept).
  logic signed [DATA_WIDTH-1:0] b_elem_q, b_best_q;
  logic [PosW-1:0]              b_addr_q;
  logic                         b_r0_q, b_c0_q, b_last_row_q;

  // Forward a write that lands in the same cycle as the read of that column
  // (back-to-back elements of a one-column matrix).
  logic                         fwd_hit_q;
  logic signed [DATA_WIDTH-1:0] fwd_data_q;

  msp_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (MAX_DIM)
  ) u_colmax_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire),
    .waddr_i (b_addr_q),
    .wdata_i (col_new),
    .re_i    (accept),
    .raddr_i (col_pos_q),
    .rdata_o (ram_rdata)
  );

  assign col_old = fwd_hit_q ? fwd_data_q : $signed(ram_rdata);
  assign col_new = (b_r0_q || b_elem_q > col_old) ? b_elem_q : col_old;

  // Minimax: smallest finished column maximum, gathered across the last row.
  always_comb begin
    least_d = least_q;
    if (b_fire && b_last_row_q && (b_c0_q || col_new < least_q)) begin
      least_d = col_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_emit_q  <= 1'b0;
      least_q   <= '0;
    end else begin
      least_q <= least_d;
      if (!stall) begin
        b_valid_q <= accept;
      end
      if (accept) begin
        b_emit_q <= is_last_col && is_last_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_elem_q     <= elem_v;
      b_best_q     <= best_d;
      b_addr_q     <= col_pos_q;
      b_r0_q       <= is_r0;
      b_c0_q       <= is_c0;
      b_last_row_q <= is_last_row;
      fwd_hit_q    <= b_fire && (b_addr_q == col_pos_q);
      fwd_data_q   <= col_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                         res_exists_q;
  logic signed [DATA_WIDTH-1:0] res_value_q;
  logic                         res_load;

  assign res_load = b_fire && b_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_exists_q <= (b_best_q == least_d);
      res_value_q  <= b_best_q;
    end
  end

  assign result_o.valid         = res_valid_q;
  assign result_o.saddle_exists = res_exists_q;
  assign result_o.saddle_value  = res_value_q;

endmodule

// ===== rtl/msp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Read returns the old content on a same-address write. No dependencies.
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/msp_checker.sv =====
// Port-level checks for the saddle point detector, bound to the top level.
// Depends on msp_pkg for the data width.
module msp_checker #(
  parameter int DATA_WIDTH = msp_pkg::DATA_WIDTH
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  elem_valid_i,
  input logic                  elem_ready_i,
  input logic                  res_valid_i,
  input logic                  res_ready_i,
  input logic                  res_exists_i,
  input logic [DATA_WIDTH-1:0] res_value_i
);

  // Hold a result word until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_exists_i) && $stable(res_value_i))
    else $error("result word changed while stalled");

  // Input backpressure only comes from an unread result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !elem_ready_i |-> res_valid_i && !res_ready_i)
    else $error("element input stalled without output backpressure");

  // A fresh result traces back to an accepted element, through stage B and the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(elem_valid_i && elem_ready_i, 2))
    else $error("result word appeared without a matching element");

endmodule

bind matrix_saddle_point_detector_top msp_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_msp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .elem_valid_i (elem_i.valid),
  .elem_ready_i (elem_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_exists_i (result_o.saddle_exists),
  .res_value_i  (result_o.saddle_value)
);

// ===== dv/tb.sv =====
// Self-checking testbench for matrix_saddle_point_detector_top: streams matrix element words,
// predicts the maximin/minimax result of each matrix, and checks every result word in order.
// Depends on msp_pkg, msp_elem_if, msp_result_if and the detector RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = msp_pkg::DATA_WIDTH;
  localparam int CW = msp_pkg::CNT_W;
  localparam int PHASES = 14;
  localparam int HOLD_CYCLES = 400;

  typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pacing_e;

  typedef struct packed {
    logic                 exists;
    logic signed [DW-1:0] value;
  } saddle_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [msp_pkg::APB_AW-1:0]    paddr;
  logic [msp_pkg::APB_DW-1:0]    pwdata;
  logic [msp_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  msp_elem_if   elem_if ();
  msp_result_if res_if ();

  matrix_saddle_point_detector_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .elem_i   (elem_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk_i = ~clk_i;

  // Element words waiting to be offered, and results owed by accepted words.
  logic signed [DW-1:0] elem_q[$];
  saddle_t              saddle_due[$];

  int  fault_count = 0;
  int  reg_faults = 0;
  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  bit  pressure_armed = 1'b0;
  bit  results_held = 1'b0;

  // Mirror of the detector: count registers, running extrema and position counters.
  logic [CW-1:0]        rows_reg = msp_pkg::CNT_RESET;
  logic [CW-1:0]        cols_reg = msp_pkg::CNT_RESET;
  logic signed [DW-1:0] col_peak[msp_pkg::MAX_DIM] = '{default: '0};
  bit                   col_written[msp_pkg::MAX_DIM] = '{default: 1'b0};
  logic signed [DW-1:0] row_floor = '0;
  logic signed [DW-1:0] best_floor = '0;
  logic signed [DW-1:0] least_peak = '0;
  logic [3:0]           row_pos = '0;
  logic [3:0]           col_pos = '0;

  // Phase plan: count register values, words offered, and pacing by phase index mod 4.
  // The 16x16 phase stops mid-matrix, so the next one shrinks rows onto a last row
  // that starts at a nonzero column. Zero and values above the bound are covered too.
  int phase_rows [PHASES] = '{1, 2, 0, 4, 16, 1, 31, 3, 1, 5, 2, 3, 17, 1};
  int phase_cols [PHASES] = '{1, 3, 0, 4, 16, 16, 2, 31, 5, 1, 2, 3, 1, 20};
  int phase_items[PHASES] = '{150, 121, 60, 118, 172, 101, 97, 103, 99, 100, 121, 83, 107, 100};

  function automatic int unsigned dim_in_use(logic [CW-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > msp_pkg::MAX_DIM) return msp_pkg::MAX_DIM;
    return cnt;
  endfunction

  // Fold one accepted element into the mirror; queue a result on the matrix's last word.
  task automatic fold_element(input logic signed [DW-1:0] v);
    int unsigned rows, cols, r, c, ci;
    bit          last_col, last_row;
    saddle_t     res;
    rows = dim_in_use(rows_reg);
    cols = dim_in_use(cols_reg);
    r = row_pos;
    c = col_pos;
    ci = (c < msp_pkg::MAX_DIM) ? c : msp_pkg::MAX_DIM - 1;
    last_col = (c + 1 >= cols);
    last_row = (r + 1 >= rows);
    if (c == 0 || v < row_floor) row_floor = v;
    if (r == 0 || v > col_peak[ci]) col_peak[ci] = v;
    if (r == 0) col_written[ci] = 1'b1;
    if (last_col && (r == 0 || row_floor > best_floor)) best_floor = row_floor;
    if (last_row && (c == 0 || col_peak[ci] < least_peak)) least_peak = col_peak[ci];
    if (last_col) begin
      col_pos = '0;
      if (last_row) begin
        row_pos = '0;
        res.exists = (best_floor == least_peak);
        res.value = best_floor;
        saddle_due.push_back(res);
      end else begin
        row_pos = 4'(r + 1);
      end
    end else begin
      col_pos = 4'(c + 1);
    end
  endtask

  // Column maxima past what row 0 wrote are undefined; never let a row past 0 read one.
  function automatic bit peaks_defined(logic [CW-1:0] cols);
    int unsigned last;
    if (row_pos == 0) return 1'b1;
    last = dim_in_use(cols) - 1;
    if (col_pos > last) last = col_pos;
    for (int i = 0; i <= last; i++) begin
      if (!col_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly small values so rows and columns tie and saddles show up; the rest spans
  // the full word and its extremes.
  function automatic logic signed [DW-1:0] draw_element();
    int roll;
    int near;
    roll = $urandom_range(99);
    near = $urandom_range(8);
    if (roll < 55) return near - 4;
    if (roll < 90) return $urandom;
    case ($urandom_range(3))
      0:       return {1'b1, {(DW-1){1'b0}}};
      1:       return {1'b0, {(DW-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Element driver: hold a word until it is taken, then advance the queue and predict.
  always @(posedge clk_i or negedge rst_ni) begin : drive_elements
    bit offer;
    if (!rst_ni) begin
      elem_if.valid <= 1'b0;
      elem_if.element <= '0;
    end else begin
      if (elem_if.valid && elem_if.ready) begin
        fold_element(elem_if.element);
        void'(elem_q.pop_front());
      end
      if (!elem_if.valid || elem_if.ready) begin
        offer = (elem_q.size() != 0) && ($urandom_range(99) >= sender_idle_pct);
        elem_if.valid <= offer;
        if (offer) elem_if.element <= elem_q[0];
      end
    end
  end

  // Result monitor: compare each accepted word with the oldest prediction, then
  // pick the next ready level.
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    saddle_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (saddle_due.size() == 0) begin
          $error("unexpected result word: saddle_exists %0b saddle_value %0d",
                 res_if.saddle_exists, res_if.saddle_value);
          fault_count++;
        end else begin
          want = saddle_due.pop_front();
          if (res_if.saddle_exists !== want.exists) begin
            $error("saddle_exists: expected %0b, got %0b", want.exists, res_if.saddle_exists);
            fault_count++;
          end
          if (res_if.saddle_value !== want.value) begin
            $error("saddle_value: expected %0d, got %0d", want.value, res_if.saddle_value);
            fault_count++;
          end
        end
      end
      res_if.ready <= !results_held && ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Long receiver hold-off: keep ready low so the block backs up and stalls its input.
  initial begin : hold_results
    wait (pressure_armed);
    @(posedge clk_i);
    results_held <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    results_held <= 1'b0;
  end

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input logic [msp_pkg::REG_IDX_W-1:0] idx,
                            input logic [msp_pkg::APB_DW-1:0] wdata,
                            output logic [msp_pkg::APB_DW-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic verify_reg(input logic [msp_pkg::REG_IDX_W-1:0] idx, input string name,
                            input logic [CW-1:0] want);
    logic [msp_pkg::APB_DW-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd[CW-1:0] !== want) begin
      $error("%s: expected %0d, got %0d", name, want, rd[CW-1:0]);
      reg_faults++;
    end
  endtask

  // Write a count with junk in the unused upper bits; only the low field may stick.
  task automatic write_count(input logic [msp_pkg::REG_IDX_W-1:0] idx, input string name,
                             input logic [CW-1:0] val);
    logic [msp_pkg::APB_DW-1:0] rd;
    logic [msp_pkg::APB_DW-1:0] wd;
    wd = $urandom;
    wd[CW-1:0] = val;
    apb_access(1'b1, idx, wd, rd);
    if (idx == msp_pkg::REG_ROW_COUNT) rows_reg = val;
    else cols_reg = val;
    verify_reg(idx, name, val);
  endtask

  task automatic wait_sent();
    while (elem_q.size() != 0 || elem_if.valid) @(posedge clk_i);
  endtask

  // Drain: all words taken, all results back, then the pipeline's own latency.
  task automatic wait_quiet();
    wait_sent();
    while (saddle_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [CW-1:0] rows, input logic [CW-1:0] cols);
    wait_quiet();
    if (!peaks_defined(cols)) begin
      // finish the matrix in flight so every column maximum gets rewritten first
      while (row_pos != 0 || col_pos != 0) begin
        elem_q.push_back(draw_element());
        wait_sent();
      end
      wait_quiet();
    end
    write_count(msp_pkg::REG_ROW_COUNT, "row_count", rows);
    write_count(msp_pkg::REG_COL_COUNT, "col_count", cols);
  endtask

  task automatic set_pacing(input pacing_e mode);
    case (mode)
      PACE_NONE: begin
        sender_idle_pct <= 0;
        receiver_stall_pct <= 0;
      end
      PACE_SENDER: begin
        sender_idle_pct <= 73;
        receiver_stall_pct <= 0;
      end
      PACE_RECEIVER: begin
        sender_idle_pct <= 0;
        receiver_stall_pct <= 73;
      end
      default: begin
        sender_idle_pct <= 19;
        receiver_stall_pct <= 19;
      end
    endcase
  endtask

  initial begin : stimulus
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Both counts must come up as a 3x3 matrix.
    verify_reg(msp_pkg::REG_ROW_COUNT, "row_count", msp_pkg::CNT_RESET);
    verify_reg(msp_pkg::REG_COL_COUNT, "col_count", msp_pkg::CNT_RESET);

    // Directed 3x3 matrices: word extremes first, then one with a saddle of 7.
    elem_q.push_back({1'b1, {(DW-1){1'b0}}});
    elem_q.push_back({1'b0, {(DW-1){1'b1}}});
    elem_q.push_back('0);
    elem_q.push_back('1);
    elem_q.push_back(1);
    elem_q.push_back({1'b0, {(DW-1){1'b1}}});
    elem_q.push_back({1'b1, {(DW-1){1'b0}}});
    elem_q.push_back('1);
    elem_q.push_back('0);
    for (int v = 1; v <= 9; v++) elem_q.push_back(v);
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      set_dims(CW'(phase_rows[p]), CW'(phase_cols[p]));
      set_pacing(pacing_e'(p % 4));
      // first phase is 1x1, so every word yields a result and the hold-off backs it up
      if (p == 0) pressure_armed = 1'b1;
      for (int n = 0; n < phase_items[p]; n++) elem_q.push_back(draw_element());
      wait_sent();
    end

    wait_quiet();
    repeat (10) @(posedge clk_i);
    if (fault_count + reg_faults == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
